/* rtl/clcd_pkg.sv */
// Shared types, codes and init tables for the character LCD command sequencer.
`default_nettype none

package clcd_pkg;

  localparam int CFG_W         = 20;
  localparam int TIMER_W_DEF   = 20;
  localparam int CFG_ADDR_W    = 3;
  localparam int REQ_W         = 3;
  localparam int PHASE_W       = 5;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 16;

  localparam logic [CFG_W-1:0] CMD_PULSE_RST   = 20'd4000;
  localparam logic [CFG_W-1:0] CHAR_PULSE_RST  = 20'd40;
  localparam logic [CFG_W-1:0] POWER_WAIT_RST  = 20'd105000;
  localparam logic [CFG_W-1:0] SHORT_WAIT_RST  = 20'd5000;
  localparam logic [CFG_W-1:0] SETTLE_WAIT_RST = 20'd55;

  localparam logic [7:0] LCD_WAKE      = 8'h30;
  localparam logic [7:0] LCD_FUNC_SET  = 8'h38;
  localparam logic [7:0] LCD_DISP_OFF  = 8'h08;
  localparam logic [7:0] LCD_CLR_DISP  = 8'h01;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
  localparam logic [7:0] LCD_NULL      = 8'h00;
  localparam logic [7:0] LCD_ROW1_BASE = 8'h80;
  localparam logic [7:0] LCD_ROW2_BASE = 8'hC0;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_INIT   = 3'd1,
    REQ_CMD    = 3'd2,
    REQ_CHAR   = 3'd3,
    REQ_CURSOR = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CMD_PULSE   = 3'd0,
    CFG_CHAR_PULSE  = 3'd1,
    CFG_POWER_WAIT  = 3'd2,
    CFG_SHORT_WAIT  = 3'd3,
    CFG_SETTLE_WAIT = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    WAIT_SHORT,
    WAIT_POWER,
    WAIT_SETTLE
  } wait_sel_e;

  function automatic logic [7:0] init_byte(logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0, 3'd1, 3'd2: b = LCD_WAKE;
      3'd3:             b = LCD_FUNC_SET;
      3'd4:             b = LCD_DISP_OFF;
      3'd5:             b = LCD_CLR_DISP;
      3'd6:             b = LCD_ENTRY;
      default:          b = LCD_DISP_ON;
    endcase
    return b;
  endfunction

  function automatic wait_sel_e init_wait(logic [2:0] idx);
    wait_sel_e w;
    case (idx)
      3'd0, 3'd5: w = WAIT_SHORT;
      3'd1, 3'd2: w = WAIT_POWER;
      default:    w = WAIT_SETTLE;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/char_lcd_command_sequencer.sv */
// Character LCD command sequencer: request decode, phase timer and pin registers.
//
//  channel | dir | handshake                  | payload
//  s_axis  | in  | s_axis_tvalid/tready       | tuser: req_type; tdata: data_byte, row, column
//  m_axis  | out | m_axis_tvalid/tready       | tdata: rs, data_pins, enable, busy_res, accepted
//  cfg     | in  | cfg_valid_i/cfg_ready_o    | cfg_addr_i: register index, cfg_data_i: value
//
// One item per cycle while the output is not stalled: an item waits in the input register, is
// decoded against the sequencer state and is then registered in the result register.
// The only loop is the state update (timer, phase, pins) of one item per clock while the output is not stalled.
// Reset clears the sequencer to idle with all pins low and loads default timings.
// A stalled output holds the result; the input register then takes at most one
// more item and holds it until the result drains. cfg writes are always ready.
`default_nettype none

module char_lcd_command_sequencer #(
  parameter int TIMER_WIDTH = clcd_pkg::TIMER_W_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] data_byte, [9:8] row, [17:10] column, [23:18] zero
  input  wire logic [clcd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] req_type
  input  wire logic [clcd_pkg::REQ_W-1:0]        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] rs, [8:1] data_pins, [9] enable, [10] busy_res, [11] accepted, [15:12] zero
  output logic [clcd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [clcd_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [clcd_pkg::CFG_W-1:0]        cfg_data_i
);
  import clcd_pkg::*;

  localparam int TW = TIMER_WIDTH;
  localparam int CW = (TW > CFG_W) ? TW : CFG_W;

  typedef enum logic [1:0] {
    KIND_IDLE,
    KIND_INIT,
    KIND_SINGLE,
    KIND_CLEAR
  } kind_e;

  function automatic logic [TW-1:0] clamp_dur(logic [CFG_W-1:0] v);
    logic [CW-1:0] ext;
    logic [CW-1:0] lim;
    ext = CW'(v);
    lim = CW'({TW{1'b1}});
    if (ext > lim) return {TW{1'b1}};
    return TW'(ext);
  endfunction

  // configuration registers
  logic [CFG_W-1:0] cmd_pulse_q, char_pulse_q, power_wait_q, short_wait_q, settle_wait_q;

  // input register
  logic             in_valid_q;
  logic [REQ_W-1:0] in_req_q;
  logic [7:0]       in_byte_q;
  logic [1:0]       in_row_q;
  logic [7:0]       in_col_q;

  // sequencer state
  kind_e              kind_q, kind_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [TW-1:0]      time_q, time_d;
  logic               rs_q, rs_d;
  logic [7:0]         data_q, data_d;
  logic               en_q, en_d;
  logic               acc_d;

  // result register
  logic             out_valid_q;
  logic             out_rs_q, out_en_q, out_busy_q, out_acc_q;
  logic [7:0]       out_data_q;

  logic advance;
  logic load_time;
  logic [CFG_W-1:0] dur;
  logic [PHASE_W-1:0] phase_inc;
  logic [2:0] wait_idx;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_acc_q, out_busy_q, out_en_q, out_data_q, out_rs_q};

  assign phase_inc = phase_q + PHASE_W'(1);
  assign wait_idx  = phase_inc[3:1] - 3'd1;

  always_comb begin
    kind_d    = kind_q;
    phase_d   = phase_q;
    time_d    = time_q;
    rs_d      = rs_q;
    data_d    = data_q;
    en_d      = en_q;
    acc_d     = 1'b0;
    load_time = 1'b0;
    dur       = cmd_pulse_q;
    if (in_req_q == REQ_TICK) begin
      if (kind_q != KIND_IDLE) begin
        if (time_q > TW'(1)) begin
          time_d = time_q - TW'(1);
        end else if (kind_q == KIND_INIT && phase_inc <= PHASE_W'(16)) begin
          phase_d = phase_inc;
          if (phase_inc[0]) begin
            rs_d   = 1'b0;
            data_d = init_byte(phase_inc[3:1]);
            en_d   = 1'b1;
            load_time = 1'b1;
            dur    = cmd_pulse_q;
          end else begin
            en_d      = 1'b0;
            load_time = 1'b1;
            case (init_wait(wait_idx))
              WAIT_POWER: dur = power_wait_q;
              WAIT_SHORT: dur = short_wait_q;
              default:    dur = settle_wait_q;
            endcase
          end
        end else if (kind_q == KIND_CLEAR && phase_inc == PHASE_W'(1)) begin
          phase_d   = phase_inc;
          en_d      = 1'b0;
          load_time = 1'b1;
          dur       = CFG_W'(1);
        end else if (kind_q == KIND_CLEAR && phase_inc == PHASE_W'(2)) begin
          phase_d   = phase_inc;
          rs_d      = 1'b0;
          data_d    = LCD_CLR_DISP;
          en_d      = 1'b1;
          load_time = 1'b1;
          dur       = cmd_pulse_q;
        end else begin
          kind_d  = KIND_IDLE;
          phase_d = '0;
          time_d  = '0;
          en_d    = 1'b0;
        end
      end
    end else if (kind_q == KIND_IDLE) begin
      phase_d = '0;
      unique case (in_req_q)
        REQ_INIT: begin
          kind_d    = KIND_INIT;
          data_d    = '0;
          en_d      = 1'b0;
          load_time = 1'b1;
          dur       = power_wait_q;
          acc_d     = 1'b1;
        end
        REQ_CMD, REQ_CHAR: begin
          kind_d    = KIND_SINGLE;
          rs_d      = (in_req_q == REQ_CHAR);
          data_d    = in_byte_q;
          en_d      = 1'b1;
          load_time = 1'b1;
          dur       = (in_req_q == REQ_CHAR) ? char_pulse_q : cmd_pulse_q;
          acc_d     = 1'b1;
        end
        REQ_CURSOR: begin
          if (in_row_q == 2'd1 || in_row_q == 2'd2) begin
            kind_d    = KIND_SINGLE;
            rs_d      = 1'b0;
            data_d    = ((in_row_q == 2'd1) ? LCD_ROW1_BASE : LCD_ROW2_BASE)
                        + in_col_q + 8'hFF;
            en_d      = 1'b1;
            load_time = 1'b1;
            dur       = cmd_pulse_q;
            acc_d     = 1'b1;
          end
        end
        REQ_CLEAR: begin
          kind_d    = KIND_CLEAR;
          rs_d      = 1'b0;
          data_d    = LCD_NULL;
          en_d      = 1'b1;
          load_time = 1'b1;
          dur       = cmd_pulse_q;
          acc_d     = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (load_time) time_d = clamp_dur(dur);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_pulse_q   <= CMD_PULSE_RST;
      char_pulse_q  <= CHAR_PULSE_RST;
      power_wait_q  <= POWER_WAIT_RST;
      short_wait_q  <= SHORT_WAIT_RST;
      settle_wait_q <= SETTLE_WAIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        CFG_CMD_PULSE:   cmd_pulse_q   <= cfg_data_i;
        CFG_CHAR_PULSE:  char_pulse_q  <= cfg_data_i;
        CFG_POWER_WAIT:  power_wait_q  <= cfg_data_i;
        CFG_SHORT_WAIT:  short_wait_q  <= cfg_data_i;
        CFG_SETTLE_WAIT: settle_wait_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata[7:0];
      in_row_q  <= s_axis_tdata[9:8];
      in_col_q  <= s_axis_tdata[17:10];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_IDLE;
      phase_q     <= '0;
      time_q      <= '0;
      rs_q        <= 1'b0;
      data_q      <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_rs_q    <= 1'b0;
      out_data_q  <= '0;
      out_en_q    <= 1'b0;
      out_busy_q  <= 1'b0;
      out_acc_q   <= 1'b0;
    end else if (advance) begin
      kind_q      <= kind_d;
      phase_q     <= phase_d;
      time_q      <= time_d;
      rs_q        <= rs_d;
      data_q      <= data_d;
      en_q        <= en_d;
      out_valid_q <= 1'b1;
      out_rs_q    <= rs_d;
      out_data_q  <= data_d;
      out_en_q    <= en_d;
      out_busy_q  <= (kind_d != KIND_IDLE);
      out_acc_q   <= acc_d;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q == KIND_IDLE |-> (time_q == '0 && phase_q == '0 && !en_q))
    else $error("idle sequencer holds live timer, phase or enable");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_acc_q |-> out_busy_q)
    else $error("accepted request without busy");

  a_single_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q == KIND_SINGLE |-> (phase_q == '0 && en_q))
    else $error("single pulse left its only phase");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == KIND_INIT |-> phase_q <= PHASE_W'(16)) and
    (kind_q == KIND_CLEAR |-> phase_q <= PHASE_W'(2)))
    else $error("phase index past end of sequence");

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input not ready with empty input register");

endmodule

`default_nettype wire

/* test/char_lcd_command_sequencer_checker.sv */
// Checker for the LCD command sequencer: tracks the pin sequence and compares every result item.
module char_lcd_command_sequencer_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [clcd_pkg::IN_TDATA_W-1:0]   in_data_i,
  input  logic [clcd_pkg::REQ_W-1:0]        in_kind_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [clcd_pkg::OUT_TDATA_W-1:0]  out_data_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [clcd_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [clcd_pkg::CFG_W-1:0]        cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                items_o,
  output int                                results_o,
  output int                                accepts_o
);
  import clcd_pkg::*;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_INIT,
    SEQ_SINGLE,
    SEQ_CLEAR
  } seq_e;

  typedef struct packed {
    logic       accepted;
    logic       busy;
    logic       en;
    logic [7:0] pins;
    logic       rs;
  } pin_word_t;

  pin_word_t pins_expected_q[$];

  logic [CFG_W-1:0] cmd_len, char_len, power_len, short_len, settle_len;
  seq_e             seq;
  logic [4:0]       step;
  logic [CFG_W-1:0] remaining;
  logic             rs_q;
  logic [7:0]       pins_q;
  logic             en_q;

  int fails, items, results, accepts;

  function automatic logic [7:0] init_code(logic [2:0] n);
    logic [7:0] code;
    case (n)
      3'd3:    code = LCD_FUNC_SET;
      3'd4:    code = LCD_DISP_OFF;
      3'd5:    code = LCD_CLR_DISP;
      3'd6:    code = LCD_ENTRY;
      3'd7:    code = LCD_DISP_ON;
      default: code = LCD_WAKE;
    endcase
    return code;
  endfunction

  function automatic logic [CFG_W-1:0] init_gap(logic [2:0] n);
    wait_sel_e sel;
    logic [CFG_W-1:0] len;
    if (n == 3'd0 || n == 3'd5) sel = WAIT_SHORT;
    else if (n == 3'd1 || n == 3'd2) sel = WAIT_POWER;
    else sel = WAIT_SETTLE;
    case (sel)
      WAIT_SHORT: len = short_len;
      WAIT_POWER: len = power_len;
      default:    len = settle_len;
    endcase
    return len;
  endfunction

  task automatic pulse(input logic [7:0] code, input logic rs, input logic [CFG_W-1:0] len);
    rs_q      = rs;
    pins_q    = code;
    en_q      = 1'b1;
    remaining = len;
  endtask

  task automatic go_idle();
    seq       = SEQ_IDLE;
    step      = '0;
    remaining = '0;
    en_q      = 1'b0;
  endtask

  task automatic enter_step(output bit alive);
    logic [4:0] half;
    alive = 1'b1;
    half  = (step - 5'd1) >> 1;
    case (seq)
      SEQ_INIT: begin
        if (step == 5'd0) begin
          pins_q    = '0;
          en_q      = 1'b0;
          remaining = power_len;
        end else if (step > 5'd16) begin
          alive = 1'b0;
        end else if (step[0]) begin
          pulse(init_code(half[2:0]), 1'b0, cmd_len);
        end else begin
          // wait after command number half
          en_q      = 1'b0;
          remaining = init_gap(half[2:0]);
        end
      end
      SEQ_CLEAR: begin
        case (step)
          5'd0: pulse(LCD_NULL, 1'b0, cmd_len);
          5'd1: begin
            en_q      = 1'b0;
            remaining = CFG_W'(1);
          end
          5'd2: pulse(LCD_CLR_DISP, 1'b0, cmd_len);
          default: alive = 1'b0;
        endcase
      end
      default: alive = 1'b0;
    endcase
  endtask

  task automatic advance_timer();
    bit alive;
    if (seq != SEQ_IDLE) begin
      // a zero duration behaves like one tick
      if (remaining > 1) begin
        remaining = remaining - 1'b1;
      end else if (seq == SEQ_SINGLE) begin
        go_idle();
      end else begin
        step = step + 5'd1;
        enter_step(alive);
        if (!alive) go_idle();
      end
    end
  endtask

  task automatic lcd_step(input logic [2:0] kind, input logic [7:0] code, input logic [1:0] row,
                          input logic [7:0] col, output pin_word_t word);
    logic took;
    bit   alive;
    took = 1'b0;
    if (kind == REQ_TICK) begin
      advance_timer();
    end else if (seq == SEQ_IDLE) begin
      case (kind)
        REQ_INIT: begin
          seq  = SEQ_INIT;
          step = '0;
          enter_step(alive);
          took = 1'b1;
        end
        REQ_CMD: begin
          seq  = SEQ_SINGLE;
          step = '0;
          pulse(code, 1'b0, cmd_len);
          took = 1'b1;
        end
        REQ_CHAR: begin
          seq  = SEQ_SINGLE;
          step = '0;
          pulse(code, 1'b1, char_len);
          took = 1'b1;
        end
        REQ_CURSOR: begin
          if (row == 2'd1 || row == 2'd2) begin
            seq  = SEQ_SINGLE;
            step = '0;
            pulse(((row == 2'd1) ? LCD_ROW1_BASE : LCD_ROW2_BASE) + col - 8'd1, 1'b0, cmd_len);
            took = 1'b1;
          end
        end
        REQ_CLEAR: begin
          seq  = SEQ_CLEAR;
          step = '0;
          enter_step(alive);
          took = 1'b1;
        end
        default: ;
      endcase
    end
    word.rs       = rs_q;
    word.pins     = pins_q;
    word.en       = en_q;
    word.busy     = (seq != SEQ_IDLE);
    word.accepted = took;
  endtask

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      fails++;
      if (fails <= 10) $display("mismatch on %s: expected %0h, got %0h", field, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pin_word_t got, want;
    if (!rst_ni) begin
      cmd_len    = CMD_PULSE_RST;
      char_len   = CHAR_PULSE_RST;
      power_len  = POWER_WAIT_RST;
      short_len  = SHORT_WAIT_RST;
      settle_len = SETTLE_WAIT_RST;
      go_idle();
      rs_q       = 1'b0;
      pins_q     = '0;
      pins_expected_q.delete();
      fails      = 0;
      items      = 0;
      results    = 0;
      accepts    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[11:0];
        results++;
        if (pins_expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result %0h arrived with nothing expected", out_data_i);
        end else begin
          want = pins_expected_q.pop_front();
          check_field("rs", want.rs, got.rs);
          check_field("data pins", want.pins, got.pins);
          check_field("enable", want.en, got.en);
          check_field("busy", want.busy, got.busy);
          check_field("accepted", want.accepted, got.accepted);
        end
      end
      if (in_valid_i && in_ready_i) begin
        lcd_step(in_kind_i, in_data_i[7:0], in_data_i[9:8], in_data_i[17:10], want);
        pins_expected_q.push_back(want);
        items++;
        if (want.accepted) accepts++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          CFG_CMD_PULSE:   cmd_len    = cfg_data_i;
          CFG_CHAR_PULSE:  char_len   = cfg_data_i;
          CFG_POWER_WAIT:  power_len  = cfg_data_i;
          CFG_SHORT_WAIT:  short_len  = cfg_data_i;
          CFG_SETTLE_WAIT: settle_len = cfg_data_i;
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= pins_expected_q.size();
    items_o      <= items;
    results_o    <= results;
    accepts_o    <= accepts;
  end

endmodule

/* test/char_lcd_command_sequencer_tb.sv */
// Testbench top for the LCD command sequencer: clock, reset, stimulus and verdict.
module char_lcd_command_sequencer_tb;
  import clcd_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED7 = 3'd7;
  localparam logic [CFG_W-1:0] TIME_MAX    = '1;
  localparam int unsigned      CYCLE_LIMIT = 300000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [REQ_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;

  int          fail_count, pending, items, results, accepts;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;

  char_lcd_command_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  char_lcd_command_sequencer_checker pin_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_kind_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .items_o      (items),
    .results_o    (results),
    .accepts_o    (accepts)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 38);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input logic [REQ_W-1:0] kind, input logic [7:0] code,
                           input logic [1:0] row, input logic [7:0] col);
    while (!steady && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'd0, col, row, code};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic ticks(input int n);
    repeat (n) send_item(REQ_TICK, 8'($urandom_range(255)), 2'($urandom_range(3)),
                         8'($urandom_range(255)));
  endtask

  // stop sending and let every outstanding item drain
  task automatic quiesce(input int extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] cmd, input logic [CFG_W-1:0] chr,
                            input logic [CFG_W-1:0] pwr, input logic [CFG_W-1:0] shrt,
                            input logic [CFG_W-1:0] stl);
    write_reg(CFG_CMD_PULSE, cmd);
    write_reg(CFG_CHAR_PULSE, chr);
    write_reg(CFG_POWER_WAIT, pwr);
    write_reg(CFG_SHORT_WAIT, shrt);
    write_reg(CFG_SETTLE_WAIT, stl);
  endtask

  // long_waits: init and char writes would never finish, so they become ticks
  task automatic random_item(input bit long_waits);
    int               pick;
    logic [REQ_W-1:0] kind;
    logic [7:0]       code;
    logic [1:0]       row;
    logic [7:0]       col;
    pick = $urandom_range(99);
    code = 8'($urandom_range(255));
    row  = 2'($urandom_range(3));
    col  = 8'($urandom_range(255));
    if ($urandom_range(7) == 0) col = $urandom_range(1) ? 8'hFF : 8'h00;
    if (pick < 55)      kind = REQ_TICK;
    else if (pick < 60) kind = long_waits ? REQ_TICK : REQ_INIT;
    else if (pick < 70) kind = REQ_CMD;
    else if (pick < 80) kind = long_waits ? REQ_TICK : REQ_CHAR;
    else if (pick < 90) kind = REQ_CURSOR;
    else if (pick < 96) kind = REQ_CLEAR;
    else                kind = pick[0] ? REQ_UNUSED6 : REQ_UNUSED7;
    send_item(kind, code, row, col);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timings: a char write holds enable for the default pulse
    send_item(REQ_CHAR, 8'h41, 2'd0, 8'd0);
    send_item(REQ_CMD, 8'h01, 2'd0, 8'd0);
    ticks(40);
    quiesce(4);

    set_timing(1, 0, 0, 1, 0);
    send_item(REQ_TICK, 8'hFF, 2'd3, 8'hFF);
    send_item(REQ_UNUSED6, 8'h12, 2'd1, 8'd1);
    send_item(REQ_UNUSED7, 8'h34, 2'd2, 8'd1);
    send_item(REQ_CURSOR, 8'h00, 2'd0, 8'd5);
    send_item(REQ_CURSOR, 8'h00, 2'd3, 8'd5);
    send_item(REQ_INIT, 8'h00, 2'd0, 8'd0);
    send_item(REQ_INIT, 8'h00, 2'd0, 8'd0);
    ticks(17);
    send_item(REQ_CMD, 8'h00, 2'd0, 8'd0);
    send_item(REQ_CHAR, 8'hFF, 2'd0, 8'd0);
    ticks(1);
    send_item(REQ_CHAR, 8'hFF, 2'd0, 8'd0);
    ticks(1);
    send_item(REQ_CHAR, 8'h00, 2'd0, 8'd0);
    ticks(1);
    send_item(REQ_CURSOR, 8'h00, 2'd1, 8'd0);
    ticks(1);
    send_item(REQ_CURSOR, 8'h00, 2'd2, 8'd255);
    ticks(1);
    send_item(REQ_CURSOR, 8'h00, 2'd1, 8'd1);
    ticks(1);
    send_item(REQ_CLEAR, 8'h00, 2'd0, 8'd0);
    send_item(REQ_CMD, 8'h55, 2'd0, 8'd0);
    ticks(3);
    send_item(REQ_CMD, 8'hFF, 2'd0, 8'd0);
    ticks(1);
    quiesce(4);

    set_timing(0, 0, 0, 0, 0);
    repeat (100) random_item(1'b0);
    quiesce(4);

    set_timing(3, 2, 5, 4, 1);
    repeat (100) random_item(1'b0);
    quiesce(4);

    steady = 1'b1;
    set_timing(CFG_W'($urandom_range(6)), CFG_W'($urandom_range(6)),
               CFG_W'($urandom_range(6)), CFG_W'($urandom_range(6)),
               CFG_W'($urandom_range(6)));
    repeat (100) random_item(1'b0);
    quiesce(4);
    steady = 1'b0;

    set_timing(2, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
    repeat (100) random_item(1'b1);
    quiesce(4);

    set_timing(CFG_W'($urandom_range(12)), CFG_W'($urandom_range(12)),
               CFG_W'($urandom_range(12)), CFG_W'($urandom_range(12)),
               CFG_W'($urandom_range(12)));
    repeat (50) random_item(1'b0);
    quiesce(0);
    repeat (50) random_item(1'b0);
    quiesce(8);

    $display("covered %0d items over seven timing settings, %0d of them taken as requests",
             items, accepts);
    $display("%0d result items checked, %0d failures", results, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
